// File: src/pct2d_pkg.sv
// ----------------------------------------------------------------------------
// pct2d_pkg
// Shared constants for the 2D pair collision test: shape kinds, test modes
// and default word format.
// ----------------------------------------------------------------------------
package pct2d_pkg;

  localparam int DEF_FRAC_BITS = 16;
  localparam int DEF_WORD_BITS = 32;

  localparam logic [1:0] KIND_PLANE  = 2'd0;
  localparam logic [1:0] KIND_CIRCLE = 2'd1;
  localparam logic [1:0] KIND_BOX    = 2'd2;
  // reserved kind code, never hits anything
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_PLANE  = 2'd1;
  localparam logic [1:0] MODE_ROUND  = 2'd2;
  localparam logic [1:0] MODE_BOXBOX = 2'd3;

endpackage

// File: src/pair_collision_test_2d_top.sv
// ----------------------------------------------------------------------------
// pair_collision_test_2d_top
// Narrow-phase test of one pair of 2D shapes (plane, circle, axis-aligned
// box): hit flag, unit contact normal and penetration depth in fixed point.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start is high; busy never rises.
// Each request gives one result, marked by done for one cycle, in request
// order. The result passes through four setup stages, the square-root
// pipeline (one root bit per stage) and the normal divider (one quotient bit
// per stage), then the output register; throughput is one pair per clock.
// The receiver cannot stall the block, so done results must be taken when
// shown.
// ----------------------------------------------------------------------------
module pair_collision_test_2d_top #(
  parameter int FRAC_BITS = pct2d_pkg::DEF_FRAC_BITS,
  parameter int WORD_BITS = pct2d_pkg::DEF_WORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  kind_a,
  input  logic signed [WORD_BITS-1:0] a_p0,
  input  logic signed [WORD_BITS-1:0] a_p1,
  input  logic signed [WORD_BITS-1:0] a_s0,
  input  logic [WORD_BITS-2:0]        a_s1,
  input  logic [1:0]                  kind_b,
  input  logic signed [WORD_BITS-1:0] b_p0,
  input  logic signed [WORD_BITS-1:0] b_p1,
  input  logic signed [WORD_BITS-1:0] b_s0,
  input  logic [WORD_BITS-2:0]        b_s1,
  output logic                        done,
  output logic                        hit,
  output logic signed [WORD_BITS-1:0] normal_x,
  output logic signed [WORD_BITS-1:0] normal_y,
  output logic [WORD_BITS-2:0]        depth
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int DW  = 2 * W + 3;
  localparam int LAT = W + F + 8;

  localparam logic [W-2:0] DMAX = '1;
  localparam logic [W-1:0] ONE  = W'(1) << F;

  typedef struct packed {
    logic         is_round;
    logic         e_hit;
    logic [W-1:0] e_nx;
    logic [W-1:0] e_ny;
    logic [W-2:0] e_depth;
    logic         r_hit;
    logic [W-1:0] reach;
    logic         sx;
    logic         sy;
  } side_t;

  typedef struct packed {
    side_t        s;
    logic [W-1:0] mx;
    logic [W-1:0] my;
  } sq_side_t;

  typedef struct packed {
    side_t        s;
    logic [W-1:0] len;
  } dv_side_t;

  assign busy = 1'b0;

  // ---------------------------------------------------------------- stage 1
  logic [1:0]          mode;
  logic                pl_is_a;
  logic                bx_is_a;
  logic                cc;
  logic [W-2:0]        nna;
  logic [W-2:0]        nnb;
  logic signed [W-1:0] pl_p0;
  logic signed [W-1:0] pl_p1;
  logic signed [W-1:0] o_p0;
  logic signed [W-1:0] o_p1;
  logic signed [W-1:0] c_p0;
  logic signed [W-1:0] c_p1;
  logic signed [W-1:0] bs_p0;
  logic signed [W-1:0] bs_p1;

  assign nna = a_s0[W-1] ? '0 : a_s0[W-2:0];
  assign nnb = b_s0[W-1] ? '0 : b_s0[W-2:0];

  always_comb begin
    mode    = pct2d_pkg::MODE_NONE;
    pl_is_a = 1'b0;
    bx_is_a = 1'b0;
    cc      = 1'b0;
    unique case (kind_a)
      pct2d_pkg::KIND_PLANE: begin
        pl_is_a = 1'b1;
        if (kind_b == pct2d_pkg::KIND_CIRCLE || kind_b == pct2d_pkg::KIND_BOX) begin
          mode = pct2d_pkg::MODE_PLANE;
        end
      end
      pct2d_pkg::KIND_CIRCLE: begin
        unique case (kind_b)
          pct2d_pkg::KIND_PLANE:  mode = pct2d_pkg::MODE_PLANE;
          pct2d_pkg::KIND_CIRCLE: begin
            mode = pct2d_pkg::MODE_ROUND;
            cc   = 1'b1;
          end
          pct2d_pkg::KIND_BOX:    mode = pct2d_pkg::MODE_ROUND;
          default:                mode = pct2d_pkg::MODE_NONE;
        endcase
      end
      pct2d_pkg::KIND_BOX: begin
        bx_is_a = 1'b1;
        unique case (kind_b)
          pct2d_pkg::KIND_PLANE:  mode = pct2d_pkg::MODE_PLANE;
          pct2d_pkg::KIND_CIRCLE: mode = pct2d_pkg::MODE_ROUND;
          pct2d_pkg::KIND_BOX:    mode = pct2d_pkg::MODE_BOXBOX;
          default:                mode = pct2d_pkg::MODE_NONE;
        endcase
      end
      default: mode = pct2d_pkg::MODE_NONE;
    endcase
  end

  assign pl_p0 = pl_is_a ? a_p0 : b_p0;
  assign pl_p1 = pl_is_a ? a_p1 : b_p1;
  assign o_p0  = pl_is_a ? b_p0 : a_p0;
  assign o_p1  = pl_is_a ? b_p1 : a_p1;
  assign c_p0  = bx_is_a ? b_p0 : a_p0;
  assign c_p1  = bx_is_a ? b_p1 : a_p1;
  assign bs_p0 = bx_is_a ? a_p0 : b_p0;
  assign bs_p1 = bx_is_a ? a_p1 : b_p1;

  logic                vld_1;
  logic [1:0]          mode_1;
  logic signed [W-1:0] pp0_1;
  logic signed [W-1:0] pp1_1;
  logic signed [W-1:0] pn0_1;
  logic signed [W-1:0] pn1_1;
  logic signed [W-1:0] pofs_1;
  logic [W-1:0]        pm0_1;
  logic [W-1:0]        pm1_1;
  logic                pcirc_1;
  logic [W-2:0]        pr_1;
  logic [W-2:0]        ps1_1;
  logic signed [W:0]   ox_1;
  logic signed [W:0]   oy_1;
  logic [W-2:0]        ex_1;
  logic [W-2:0]        ey_1;
  logic [W-1:0]        reach_1;
  logic signed [W:0]   axl_1;
  logic signed [W:0]   axh_1;
  logic signed [W:0]   ayl_1;
  logic signed [W:0]   ayh_1;
  logic signed [W:0]   bxl_1;
  logic signed [W:0]   bxh_1;
  logic signed [W:0]   byl_1;
  logic signed [W:0]   byh_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_1 <= 1'b0;
    end else begin
      vld_1 <= start & ~busy;
    end
    mode_1  <= mode;
    pp0_1   <= o_p0;
    pp1_1   <= o_p1;
    pn0_1   <= pl_p0;
    pn1_1   <= pl_p1;
    pofs_1  <= pl_is_a ? a_s0 : b_s0;
    pm0_1   <= pl_p0[W-1] ? W'(-pl_p0) : W'(pl_p0);
    pm1_1   <= pl_p1[W-1] ? W'(-pl_p1) : W'(pl_p1);
    pcirc_1 <= pl_is_a ? (kind_b == pct2d_pkg::KIND_CIRCLE)
                       : (kind_a == pct2d_pkg::KIND_CIRCLE);
    pr_1    <= pl_is_a ? nnb : nna;
    ps1_1   <= pl_is_a ? b_s1 : a_s1;
    ox_1    <= (W+1)'(c_p0) - (W+1)'(bs_p0);
    oy_1    <= (W+1)'(c_p1) - (W+1)'(bs_p1);
    ex_1    <= cc ? '0 : (bx_is_a ? nna : nnb);
    ey_1    <= cc ? '0 : (bx_is_a ? a_s1 : b_s1);
    reach_1 <= cc ? (W'(nna) + W'(nnb)) : W'(bx_is_a ? nnb : nna);
    axl_1   <= (W+1)'(a_p0) - (W+1)'(nna);
    axh_1   <= (W+1)'(a_p0) + (W+1)'(nna);
    ayl_1   <= (W+1)'(a_p1) - (W+1)'(a_s1);
    ayh_1   <= (W+1)'(a_p1) + (W+1)'(a_s1);
    bxl_1   <= (W+1)'(b_p0) - (W+1)'(nnb);
    bxh_1   <= (W+1)'(b_p0) + (W+1)'(nnb);
    byl_1   <= (W+1)'(b_p1) - (W+1)'(b_s1);
    byh_1   <= (W+1)'(b_p1) + (W+1)'(b_s1);
  end

  // ---------------------------------------------------------------- stage 2
  logic signed [W+1:0] oxe;
  logic signed [W+1:0] oye;
  logic signed [W+1:0] sex;
  logic signed [W+1:0] sey;
  logic signed [W+1:0] vx;
  logic signed [W+1:0] vy;
  logic signed [W+1:0] lox;
  logic signed [W+1:0] hix;
  logic signed [W+1:0] loy;
  logic signed [W+1:0] hiy;
  logic [W+1:0]        mlox;
  logic [W+1:0]        mhix;
  logic [W+1:0]        mloy;
  logic [W+1:0]        mhiy;

  assign oxe = (W+2)'(ox_1);
  assign oye = (W+2)'(oy_1);
  assign sex = (W+2)'(ex_1);
  assign sey = (W+2)'(ey_1);

  // distance from the box to the circle center after clamping
  always_comb begin
    if (oxe > sex) begin
      vx = oxe - sex;
    end else if (oxe < -sex) begin
      vx = oxe + sex;
    end else begin
      vx = '0;
    end
    if (oye > sey) begin
      vy = oye - sey;
    end else if (oye < -sey) begin
      vy = oye + sey;
    end else begin
      vy = '0;
    end
  end

  assign lox  = (W+2)'(axl_1) - (W+2)'(bxh_1);
  assign hix  = (W+2)'(axh_1) - (W+2)'(bxl_1);
  assign loy  = (W+2)'(ayl_1) - (W+2)'(byh_1);
  assign hiy  = (W+2)'(ayh_1) - (W+2)'(byl_1);
  assign mlox = lox[W+1] ? (W+2)'(-lox) : (W+2)'(lox);
  assign mhix = hix[W+1] ? (W+2)'(-hix) : (W+2)'(hix);
  assign mloy = loy[W+1] ? (W+2)'(-loy) : (W+2)'(loy);
  assign mhiy = hiy[W+1] ? (W+2)'(-hiy) : (W+2)'(hiy);

  logic                  vld_2;
  logic [1:0]            mode_2;
  logic signed [2*W-1:0] m0_2;
  logic signed [2*W-1:0] m1_2;
  logic [2*W-2:0]        b0_2;
  logic [2*W-2:0]        b1_2;
  logic                  pcirc_2;
  logic [W-2:0]          pr_2;
  logic signed [W-1:0]   pofs_2;
  logic signed [W-1:0]   pn0_2;
  logic signed [W-1:0]   pn1_2;
  logic signed [W+1:0]   vx_2;
  logic signed [W+1:0]   vy_2;
  logic [W-1:0]          reach_2;
  logic                  bbov_2;
  logic signed [W+1:0]   bx_2;
  logic signed [W+1:0]   by_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_2 <= 1'b0;
    end else begin
      vld_2 <= vld_1;
    end
    mode_2  <= mode_1;
    m0_2    <= (2*W)'(pp0_1) * (2*W)'(pn0_1);
    m1_2    <= (2*W)'(pp1_1) * (2*W)'(pn1_1);
    b0_2    <= (2*W-1)'(pr_1) * (2*W-1)'(pm0_1);
    b1_2    <= (2*W-1)'(ps1_1) * (2*W-1)'(pm1_1);
    pcirc_2 <= pcirc_1;
    pr_2    <= pr_1;
    pofs_2  <= pofs_1;
    pn0_2   <= pn0_1;
    pn1_2   <= pn1_1;
    vx_2    <= vx;
    vy_2    <= vy;
    reach_2 <= reach_1;
    bbov_2  <= (bxl_1 < axh_1) && (byl_1 < ayh_1) && (axl_1 < bxh_1) && (ayl_1 < byh_1);
    // keep the smaller overlap per axis, the second on a tie
    bx_2    <= (mlox < mhix) ? lox : hix;
    by_2    <= (mloy < mhiy) ? loy : hiy;
  end

  // ---------------------------------------------------------------- stage 3
  logic signed [2*W:0]    dsum;
  logic signed [2*W:0]    dot;
  logic [2*W-1:0]         bsum;
  logic signed [DW-1:0]   psub;
  logic [W+1:0]           mvx;
  logic [W+1:0]           mvy;
  logic [W+1:0]           mbx;
  logic [W+1:0]           mby;
  logic                   bb_hit;
  logic [W-1:0]           bb_nx;
  logic [W-1:0]           bb_ny;
  logic [W-2:0]           bb_depth;

  assign dsum = (2*W+1)'(m0_2) + (2*W+1)'(m1_2);
  assign dot  = dsum >>> F;
  assign bsum = (2*W)'(b0_2) + (2*W)'(b1_2);
  assign psub = pcirc_2 ? DW'(pr_2) : DW'(bsum >> F);
  assign mvx  = vx_2[W+1] ? (W+2)'(-vx_2) : (W+2)'(vx_2);
  assign mvy  = vy_2[W+1] ? (W+2)'(-vy_2) : (W+2)'(vy_2);
  assign mbx  = bx_2[W+1] ? (W+2)'(-bx_2) : (W+2)'(bx_2);
  assign mby  = by_2[W+1] ? (W+2)'(-by_2) : (W+2)'(by_2);

  // box-box: the axis of least overlap wins, y on a tie
  always_comb begin
    bb_hit   = bbov_2;
    bb_nx    = '0;
    bb_ny    = '0;
    bb_depth = '0;
    if (bbov_2) begin
      if (mbx < mby) begin
        bb_nx    = (bx_2 > 0) ? -ONE : ((bx_2 < 0) ? ONE : '0);
        bb_depth = (mbx > (W+2)'(DMAX)) ? DMAX : mbx[W-2:0];
      end else begin
        bb_ny    = (by_2 > 0) ? -ONE : ((by_2 < 0) ? ONE : '0);
        bb_depth = (mby > (W+2)'(DMAX)) ? DMAX : mby[W-2:0];
      end
    end
  end

  logic                 vld_3;
  logic [1:0]           mode_3;
  logic signed [DW-1:0] pd_3;
  logic signed [W-1:0]  pn0_3;
  logic signed [W-1:0]  pn1_3;
  logic [2*W+1:0]       sqx_3;
  logic [2*W+1:0]       sqy_3;
  logic [2*W-1:0]       r2_3;
  logic [W-1:0]         reach_3;
  logic                 sx_3;
  logic                 sy_3;
  logic [W:0]           mvx_3;
  logic [W:0]           mvy_3;
  logic                 bbh_3;
  logic [W-1:0]         bbnx_3;
  logic [W-1:0]         bbny_3;
  logic [W-2:0]         bbd_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_3 <= 1'b0;
    end else begin
      vld_3 <= vld_2;
    end
    mode_3  <= mode_2;
    pd_3    <= DW'(dot) + DW'(pofs_2) - psub;
    pn0_3   <= pn0_2;
    pn1_3   <= pn1_2;
    sqx_3   <= (2*W+2)'(mvx[W:0]) * (2*W+2)'(mvx[W:0]);
    sqy_3   <= (2*W+2)'(mvy[W:0]) * (2*W+2)'(mvy[W:0]);
    r2_3    <= (2*W)'(reach_2) * (2*W)'(reach_2);
    reach_3 <= reach_2;
    sx_3    <= vx_2[W+1];
    sy_3    <= vy_2[W+1];
    mvx_3   <= mvx[W:0];
    mvy_3   <= mvy[W:0];
    bbh_3   <= bb_hit;
    bbnx_3  <= bb_nx;
    bbny_3  <= bb_ny;
    bbd_3   <= bb_depth;
  end

  // ---------------------------------------------------------------- stage 4
  logic signed [DW-1:0] pneg;
  logic [2*W+2:0]       d2;
  side_t                side_4n;

  assign pneg = -pd_3;
  assign d2   = (2*W+3)'(sqx_3) + (2*W+3)'(sqy_3);

  always_comb begin
    side_4n          = '0;
    side_4n.is_round = (mode_3 == pct2d_pkg::MODE_ROUND);
    side_4n.r_hit    = side_4n.is_round && (d2 < (2*W+3)'(r2_3));
    side_4n.reach    = reach_3;
    side_4n.sx       = sx_3;
    side_4n.sy       = sy_3;
    unique case (mode_3)
      pct2d_pkg::MODE_PLANE: begin
        if (pd_3 < 0) begin
          side_4n.e_hit   = 1'b1;
          side_4n.e_nx    = pn0_3;
          side_4n.e_ny    = pn1_3;
          side_4n.e_depth = (pneg > DW'(DMAX)) ? DMAX : pneg[W-2:0];
        end
      end
      pct2d_pkg::MODE_BOXBOX: begin
        side_4n.e_hit   = bbh_3;
        side_4n.e_nx    = bbnx_3;
        side_4n.e_ny    = bbny_3;
        side_4n.e_depth = bbd_3;
      end
      pct2d_pkg::MODE_ROUND: side_4n.e_hit = 1'b0;
      pct2d_pkg::MODE_NONE:  side_4n.e_hit = 1'b0;
      default:               side_4n.e_hit = 1'b0;
    endcase
  end

  logic           vld_4;
  logic [2*W-1:0] rad_4;
  sq_side_t       sq_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_4 <= 1'b0;
    end else begin
      vld_4 <= vld_3;
    end
    // on a hit d2 is below 2^(2W), so the low bits are the whole radicand
    rad_4   <= d2[2*W-1:0];
    sq_4.s  <= side_4n;
    sq_4.mx <= mvx_3[W-1:0];
    sq_4.my <= mvy_3[W-1:0];
  end

  // ------------------------------------------------------ root and divider
  logic           sq_vld;
  logic [W-1:0]   sq_root;
  sq_side_t       sq_out;
  dv_side_t       dv_in;
  logic           dv_vld;
  logic [F:0]     dv_qx;
  logic [F:0]     dv_qy;
  dv_side_t       dv_out;

  pct2d_isqrt #(
    .W      (W),
    .SIDE_W ($bits(sq_side_t))
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld_4),
    .in_rad    (rad_4),
    .in_side   (sq_4),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_out)
  );

  assign dv_in.s   = sq_out.s;
  assign dv_in.len = sq_root;

  pct2d_udiv #(
    .W      (W),
    .F      (F),
    .SIDE_W ($bits(dv_side_t))
  ) u_udiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_vld),
    .in_mx     (sq_out.mx),
    .in_my     (sq_out.my),
    .in_len    (sq_root),
    .in_side   (dv_in),
    .out_valid (dv_vld),
    .out_qx    (dv_qx),
    .out_qy    (dv_qy),
    .out_side  (dv_out)
  );

  // ---------------------------------------------------------------- output
  logic [W-1:0] qxw;
  logic [W-1:0] qyw;
  logic [W-1:0] rdep;
  logic         len_zero;

  assign qxw      = W'(dv_qx);
  assign qyw      = W'(dv_qy);
  assign rdep     = dv_out.s.reach - dv_out.len;
  assign len_zero = (dv_out.len == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_vld;
    end
    if (dv_out.s.is_round) begin
      hit      <= dv_out.s.r_hit;
      normal_x <= '0;
      normal_y <= '0;
      depth    <= '0;
      if (dv_out.s.r_hit) begin
        // drop the direction when the offset is zero (coincident centers, or a circle center inside the box)
        if (!len_zero) begin
          normal_x <= dv_out.s.sx ? -qxw : qxw;
          normal_y <= dv_out.s.sy ? -qyw : qyw;
        end
        depth <= (rdep > W'(DMAX)) ? DMAX : rdep[W-2:0];
      end
    end else begin
      hit      <= dv_out.s.e_hit;
      normal_x <= dv_out.s.e_nx;
      normal_y <= dv_out.s.e_ny;
      depth    <= dv_out.s.e_depth;
    end
  end

  // ------------------------------------------------------------ assertions
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result missing at fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !$past(start, LAT) |-> !done)
    else $error("result without request");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (normal_x == '0 && normal_y == '0 && depth == '0))
    else $error("miss with nonzero contact data");

endmodule

// File: src/pct2d_isqrt.sv
// ----------------------------------------------------------------------------
// pct2d_isqrt
// Pipelined integer square root, one root bit per stage, with a sideband
// that travels alongside each request.
// ----------------------------------------------------------------------------
module pct2d_isqrt #(
  parameter int W      = pct2d_pkg::DEF_WORD_BITS,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [2*W-1:0]    in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [W-1:0]      out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int RW = W + 3;

  logic              vld  [0:W];
  logic [2*W-1:0]    rad  [0:W];
  logic [RW-1:0]     rem  [0:W];
  logic [W-1:0]      root [0:W];
  logic [SIDE_W-1:0] side [0:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    rad[0]  <= in_rad;
    rem[0]  <= '0;
    root[0] <= '0;
    side[0] <= in_side;
  end

  for (genvar i = 0; i < W; i++) begin : g_step
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh = {rem[i][RW-3:0], rad[i][2*W-1 -: 2]};
    assign trial  = RW'({root[i], 2'b01});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      rad[i+1]  <= rad[i] << 2;
      side[i+1] <= side[i];
      if (rem_sh >= trial) begin
        rem[i+1]  <= rem_sh - trial;
        root[i+1] <= {root[i][W-2:0], 1'b1};
      end else begin
        rem[i+1]  <= rem_sh;
        root[i+1] <= {root[i][W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[W];
  assign out_root  = root[W];
  assign out_side  = side[W];

endmodule

// File: src/pct2d_udiv.sv
// ----------------------------------------------------------------------------
// pct2d_udiv
// Pipelined restoring divider for both normal components: q = m*2^F / len
// with m no larger than len, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pct2d_udiv #(
  parameter int W      = pct2d_pkg::DEF_WORD_BITS,
  parameter int F      = pct2d_pkg::DEF_FRAC_BITS,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [W-1:0]      in_mx,
  input  logic [W-1:0]      in_my,
  input  logic [W-1:0]      in_len,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [F:0]        out_qx,
  output logic [F:0]        out_qy,
  output logic [SIDE_W-1:0] out_side
);

  localparam int NS = F + 1;

  logic              vld  [0:NS];
  logic [W:0]        remx [0:NS];
  logic [W:0]        remy [0:NS];
  logic [F:0]        qx   [0:NS];
  logic [F:0]        qy   [0:NS];
  logic [W-1:0]      len  [0:NS];
  logic [SIDE_W-1:0] side [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    remx[0] <= (W+1)'(in_mx);
    remy[0] <= (W+1)'(in_my);
    qx[0]   <= '0;
    qy[0]   <= '0;
    len[0]  <= in_len;
    side[0] <= in_side;
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    logic [W:0] lenx;
    logic [W:0] shx;
    logic [W:0] shy;

    assign lenx = (W+1)'(len[i]);
    // integer bit first, fraction bits after a shift
    assign shx  = (i == 0) ? remx[i] : {remx[i][W-1:0], 1'b0};
    assign shy  = (i == 0) ? remy[i] : {remy[i][W-1:0], 1'b0};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      len[i+1]  <= len[i];
      side[i+1] <= side[i];
      if (shx >= lenx) begin
        remx[i+1] <= shx - lenx;
        qx[i+1]   <= {qx[i][F-1:0], 1'b1};
      end else begin
        remx[i+1] <= shx;
        qx[i+1]   <= {qx[i][F-1:0], 1'b0};
      end
      if (shy >= lenx) begin
        remy[i+1] <= shy - lenx;
        qy[i+1]   <= {qy[i][F-1:0], 1'b1};
      end else begin
        remy[i+1] <= shy;
        qy[i+1]   <= {qy[i][F-1:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[NS];
  assign out_qx    = qx[NS];
  assign out_qy    = qy[NS];
  assign out_side  = side[NS];

endmodule

// File: verif/pair_collision_test_2d_checker.sv
// ----------------------------------------------------------------------------
// pair_collision_test_2d_checker
// Watches the request and result ports of the pair collision test, predicts
// hit, normal and depth for every accepted request, and compares each done
// result with the oldest prediction in order.
// ----------------------------------------------------------------------------
module pair_collision_test_2d_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         kind_a,
  input  logic signed [31:0] a_p0,
  input  logic signed [31:0] a_p1,
  input  logic signed [31:0] a_s0,
  input  logic [30:0]        a_s1,
  input  logic [1:0]         kind_b,
  input  logic signed [31:0] b_p0,
  input  logic signed [31:0] b_p1,
  input  logic signed [31:0] b_s0,
  input  logic [30:0]        b_s1,
  input  logic               done,
  input  logic               hit,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_y,
  input  logic [30:0]        depth,
  output int                 fails,
  output int                 pending
);

  localparam int FB = pct2d_pkg::DEF_FRAC_BITS;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [1:0] kind;
    wide_t      p0, p1, s0, s1;
  } shape_t;

  typedef struct {
    logic        hit;
    logic [31:0] nx, ny;
    logic [30:0] depth;
  } contact_t;

  contact_t contact_q[$];

  function automatic wide_t wabs(wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic wide_t clip_neg(wide_t v);
    return (v < 0) ? wide_t'(0) : v;
  endfunction

  function automatic logic [30:0] sat_depth(wide_t v);
    if (v < 0) return '0;
    if (v > wide_t'(32'h7fff_ffff)) return 31'h7fff_ffff;
    return v[30:0];
  endfunction

  function automatic contact_t no_contact();
    contact_t c;
    c.hit = 0; c.nx = '0; c.ny = '0; c.depth = '0;
    return c;
  endfunction

  // unit component: truncated |v|*2^F/len, sign of v
  function automatic logic [31:0] unit_part(wide_t v, wide_t len);
    wide_t q;
    if (len == 0) return '0;
    q = (wabs(v) <<< FB) / len;
    return (v < 0) ? 32'(-q) : 32'(q);
  endfunction

  function automatic wide_t floor_sqrt(wide_t v);
    wide_t r, t;
    r = 0;
    for (int b = 51; b >= 0; b--) begin
      t = r | (wide_t'(1) <<< b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic contact_t plane_contact(shape_t pl, shape_t o);
    contact_t c;
    wide_t d, sub;
    d = ((o.p0 * pl.p0 + o.p1 * pl.p1) >>> FB) + pl.s0;
    if (o.kind == pct2d_pkg::KIND_CIRCLE) sub = clip_neg(o.s0);
    else sub = (clip_neg(o.s0) * wabs(pl.p0) + o.s1 * wabs(pl.p1)) >>> FB;
    d = d - sub;
    if (d >= 0) return no_contact();
    c.hit = 1;
    c.nx = pl.p0[31:0];
    c.ny = pl.p1[31:0];
    c.depth = sat_depth(-d);
    return c;
  endfunction

  function automatic contact_t round_contact(wide_t vx, wide_t vy, wide_t reach);
    contact_t c;
    wide_t d2, len;
    d2 = vx * vx + vy * vy;
    if (d2 >= reach * reach) return no_contact();
    len = floor_sqrt(d2);
    c.hit = 1;
    c.nx = unit_part(vx, len);
    c.ny = unit_part(vy, len);
    c.depth = sat_depth(reach - len);
    return c;
  endfunction

  function automatic wide_t clamp_ext(wide_t v, wide_t e);
    return (v > e) ? e : ((v < -e) ? -e : v);
  endfunction

  function automatic contact_t box_circle_contact(shape_t bx, shape_t ci);
    wide_t ox, oy;
    ox = ci.p0 - bx.p0;
    oy = ci.p1 - bx.p1;
    return round_contact(ox - clamp_ext(ox, clip_neg(bx.s0)), oy - clamp_ext(oy, bx.s1),
                         clip_neg(ci.s0));
  endfunction

  function automatic wide_t least_overlap(wide_t lo, wide_t hi);
    return (wabs(lo) < wabs(hi)) ? lo : hi;
  endfunction

  function automatic contact_t box_box_contact(shape_t a, shape_t b);
    contact_t c;
    wide_t axl, axh, ayl, ayh, bxl, bxh, byl, byh, ox, oy;
    logic [31:0] one;
    one = 32'(1) << FB;
    axl = a.p0 - clip_neg(a.s0); axh = a.p0 + clip_neg(a.s0);
    ayl = a.p1 - a.s1;           ayh = a.p1 + a.s1;
    bxl = b.p0 - clip_neg(b.s0); bxh = b.p0 + clip_neg(b.s0);
    byl = b.p1 - b.s1;           byh = b.p1 + b.s1;
    if (!(bxl < axh && byl < ayh && axl < bxh && ayl < byh)) return no_contact();
    ox = least_overlap(axl - bxh, axh - bxl);
    oy = least_overlap(ayl - byh, ayh - byl);
    c = no_contact();
    c.hit = 1;
    if (wabs(ox) < wabs(oy)) begin
      c.nx = (ox > 0) ? -one : ((ox < 0) ? one : '0);
      c.depth = sat_depth(wabs(ox));
    end else begin
      c.ny = (oy > 0) ? -one : ((oy < 0) ? one : '0);
      c.depth = sat_depth(wabs(oy));
    end
    return c;
  endfunction

  function automatic contact_t predict_contact(shape_t a, shape_t b);
    case (a.kind)
      pct2d_pkg::KIND_PLANE: begin
        if (b.kind == pct2d_pkg::KIND_CIRCLE || b.kind == pct2d_pkg::KIND_BOX)
          return plane_contact(a, b);
      end
      pct2d_pkg::KIND_CIRCLE: begin
        if (b.kind == pct2d_pkg::KIND_PLANE) return plane_contact(b, a);
        if (b.kind == pct2d_pkg::KIND_CIRCLE)
          return round_contact(a.p0 - b.p0, a.p1 - b.p1, clip_neg(a.s0) + clip_neg(b.s0));
        if (b.kind == pct2d_pkg::KIND_BOX) return box_circle_contact(b, a);
      end
      pct2d_pkg::KIND_BOX: begin
        if (b.kind == pct2d_pkg::KIND_PLANE) return plane_contact(b, a);
        if (b.kind == pct2d_pkg::KIND_CIRCLE) return box_circle_contact(a, b);
        if (b.kind == pct2d_pkg::KIND_BOX) return box_box_contact(a, b);
      end
      default: ;
    endcase
    return no_contact();
  endfunction

  assign pending = contact_q.size();

  always @(posedge clk) begin
    shape_t sa, sb;
    contact_t want;
    if (rst) begin
      fails <= 0;
    end else begin
      if (start && !busy) begin
        sa.kind = kind_a; sa.p0 = a_p0; sa.p1 = a_p1; sa.s0 = a_s0;
        sa.s1 = wide_t'({1'b0, a_s1});
        sb.kind = kind_b; sb.p0 = b_p0; sb.p1 = b_p1; sb.s0 = b_s0;
        sb.s1 = wide_t'({1'b0, b_s1});
        contact_q.insert(contact_q.size(), predict_contact(sa, sb));
      end
      if (done) begin
        if (contact_q.size() == 0) begin
          if (fails < 10) $display("ERROR: result with no request outstanding");
          fails <= fails + 1;
        end else begin
          want = contact_q.pop_front();
          if (hit !== want.hit || normal_x !== want.nx || normal_y !== want.ny ||
              depth !== want.depth) begin
            if (fails < 10)
              $display("ERROR: exp hit=%0d n=(%h,%h) d=%h got hit=%0d n=(%h,%h) d=%h",
                       want.hit, want.nx, want.ny, want.depth,
                       hit, normal_x, normal_y, depth);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

// File: verif/pair_collision_test_2d_top_tb.sv
// ----------------------------------------------------------------------------
// pair_collision_test_2d_top_tb
// Drives directed and random shape pairs into the pair collision test with
// random idle bursts; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module pair_collision_test_2d_top_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PAIRS = 1730;

  logic               clk, rst, start, busy;
  logic [1:0]         kind_a, kind_b;
  logic signed [31:0] a_p0, a_p1, a_s0, b_p0, b_p1, b_s0;
  logic [30:0]        a_s1, b_s1;
  logic               done, hit;
  logic signed [31:0] normal_x, normal_y;
  logic [30:0]        depth;
  int                 fails, pending, quiet;

  pair_collision_test_2d_top u_dut (.*);

  pair_collision_test_2d_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles with no request or result taken
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_pair(logic [1:0] ka, logic signed [31:0] ap0, ap1, as0,
                           logic [30:0] as1, logic [1:0] kb,
                           logic signed [31:0] bp0, bp1, bs0, logic [30:0] bs1);
    kind_a <= ka; a_p0 <= ap0; a_p1 <= ap1; a_s0 <= as0; a_s1 <= as1;
    kind_b <= kb; b_p0 <= bp0; b_p1 <= bp1; b_s0 <= bs0; b_s1 <= bs1;
    start  <= 1;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_idle(int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  // mostly small Q16.16 values so shapes overlap; some extremes and full range
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: case ($urandom_range(0, 4))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           2: return 32'h0;
           3: return 32'hffff_ffff;
           default: return 32'h1;
         endcase
      2, 3: return $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
      default: return $urandom_range(0, 32'h10_0000) - 32'h8_0000;
    endcase
  endfunction

  function automatic logic [1:0] pick_kind();
    return ($urandom_range(0, 19) == 0) ? pct2d_pkg::KIND_UNUSED
                                        : 2'($urandom_range(0, 2));
  endfunction

  // plane normals: usually an axis or random unit-ish, otherwise anything
  function automatic logic [31:0] pick_normal(int sel);
    case (sel)
      0: return 32'h0001_0000;
      1: return 32'hffff_0000;
      2: return 32'h0;
      3: return $urandom_range(0, 32'h2_0000) - 32'h1_0000;
      default: return pick_word();
    endcase
  endfunction

  task automatic send_random();
    logic [1:0] ka, kb;
    logic [31:0] ap0, ap1, bp0, bp1;
    int sa, sb;
    ka = pick_kind(); kb = pick_kind();
    sa = $urandom_range(0, 5); sb = $urandom_range(0, 5);
    ap0 = (ka == pct2d_pkg::KIND_PLANE) ? pick_normal(sa) : pick_word();
    ap1 = (ka == pct2d_pkg::KIND_PLANE) ? pick_normal(5 - sa) : pick_word();
    bp0 = (kb == pct2d_pkg::KIND_PLANE) ? pick_normal(sb) : pick_word();
    bp1 = (kb == pct2d_pkg::KIND_PLANE) ? pick_normal(5 - sb) : pick_word();
    send_pair(ka, ap0, ap1, pick_word(), 31'(($urandom_range(0, 3) == 0) ?
              $urandom() : $urandom_range(0, 32'h8_0000)),
              kb, bp0, bp1, pick_word(), 31'(($urandom_range(0, 3) == 0) ?
              $urandom() : $urandom_range(0, 32'h8_0000)));
  endtask

  localparam logic signed [31:0] ONE = 32'h0001_0000;
  localparam logic signed [31:0] MINW = 32'h8000_0000;
  localparam logic signed [31:0] MAXW = 32'h7fff_ffff;

  initial begin
    rst = 1; start = 0;
    kind_a = pct2d_pkg::KIND_PLANE; a_p0 = 0; a_p1 = 0; a_s0 = 0; a_s1 = 0;
    kind_b = pct2d_pkg::KIND_PLANE; b_p0 = 0; b_p1 = 0; b_s0 = 0; b_s1 = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // every kind pairing with overlapping small shapes
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        send_pair(2'(i), (i == 0) ? 0 : ONE / 2, ONE, ONE, 31'(ONE),
                  2'(j), (j == 0) ? 0 : 0, ONE, ONE * 2, 31'(ONE));
    // coincident circles, circle center inside box, negative radii
    send_pair(pct2d_pkg::KIND_CIRCLE, ONE, ONE, ONE, 0,
              pct2d_pkg::KIND_CIRCLE, ONE, ONE, ONE, 0);
    send_pair(pct2d_pkg::KIND_BOX, 0, 0, ONE * 4, 31'(ONE * 4),
              pct2d_pkg::KIND_CIRCLE, ONE, ONE, ONE, 0);
    send_pair(pct2d_pkg::KIND_CIRCLE, 0, 0, -ONE, 0,
              pct2d_pkg::KIND_BOX, 0, 0, -ONE, 31'(ONE));
    // saturated plane depth and full-range extremes
    send_pair(pct2d_pkg::KIND_PLANE, 0, ONE, MINW, 0,
              pct2d_pkg::KIND_CIRCLE, 0, 0, MAXW, 0);
    send_pair(pct2d_pkg::KIND_BOX, MAXW, MAXW, MAXW, 31'h7fff_ffff,
              pct2d_pkg::KIND_BOX, MINW, MINW, MAXW, 31'h7fff_ffff);
    send_pair(pct2d_pkg::KIND_CIRCLE, MINW, MINW, MAXW, 31'h7fff_ffff,
              pct2d_pkg::KIND_CIRCLE, MAXW, MAXW, MAXW, 31'h7fff_ffff);
    // equal overlap on both box axes
    send_pair(pct2d_pkg::KIND_BOX, 0, 0, ONE, 31'(ONE),
              pct2d_pkg::KIND_BOX, ONE, ONE, ONE, 31'(ONE));
    send_pair(pct2d_pkg::KIND_PLANE, MINW, MAXW, MAXW, 31'h7fff_ffff,
              pct2d_pkg::KIND_BOX, MAXW, MINW, MINW, 31'h7fff_ffff);

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n == RANDOM_PAIRS / 2) begin
        start <= 0;
        do @(posedge clk); while (pending != 0);
      end
      if (n < RANDOM_PAIRS - 200 && $urandom_range(0, 5) == 0)
        hold_idle($urandom_range(1, 13));
      send_random();
    end
    start <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
    if (fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// File: pair_collision_test_2d_top.f
src/pct2d_pkg.sv
src/pct2d_isqrt.sv
src/pct2d_udiv.sv
src/pair_collision_test_2d_top.sv
verif/pair_collision_test_2d_checker.sv
verif/pair_collision_test_2d_top_tb.sv
